@@ rtl/core/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, command codes and arithmetic helpers for the scope front
// panel control block.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Item commands
  localparam logic [2:0] CMD_X_EDGE    = 3'd0;
  localparam logic [2:0] CMD_Y_EDGE    = 3'd1;
  localparam logic [2:0] CMD_CAPTURE   = 3'd2;
  localparam logic [2:0] CMD_MODE      = 3'd3;
  localparam logic [2:0] CMD_BUTTONS   = 3'd4;
  localparam logic [2:0] CMD_APPLY     = 3'd5;

  // Register map: index is paddr[2]
  localparam int unsigned PADDR_W       = 3;
  localparam logic        REG_X_SHIFT_STEP = 1'b0;

  localparam int unsigned WAVE_KINDS_DEF = 5;

  localparam logic [7:0]  X_SHIFT_STEP_RESET = 8'd3;
  localparam logic [23:0] TIME_RESET  = 24'd1000;
  localparam logic [3:0]  VOLTS_RESET = 4'd1;
  localparam logic [24:0] TIME_WRAP   = 25'd10000001;

  // floor(n / 11) == (n * 187) >> 11 for n up to 137
  localparam logic [15:0] VOLTS_RECIP = 16'd187;

  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

  typedef struct packed {
    logic [23:0]        time_div;
    logic [3:0]         volts_div;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
  } sfp_grid_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    begin
      if (v > S32_MAX) begin
        r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
        r = 32'sh80000000;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

  // Largest power of ten not above t, limited to 1..1000000
  function automatic logic [19:0] decade_of(input logic [23:0] t);
    logic [19:0] f;
    begin
      if (t >= 24'd1000000) begin
        f = 20'd1000000;
      end else if (t >= 24'd100000) begin
        f = 20'd100000;
      end else if (t >= 24'd10000) begin
        f = 20'd10000;
      end else if (t >= 24'd1000) begin
        f = 20'd1000;
      end else if (t >= 24'd100) begin
        f = 20'd100;
      end else if (t >= 24'd10) begin
        f = 20'd10;
      end else begin
        f = 20'd1;
      end
      return f;
    end
  endfunction

endpackage

@@ rtl/core/sfp_apply_unit.sv @@
// ----------------------------------------------------------------------------
// sfp_apply_unit
// Drains the X and Y step counts into time/div, volts/div and the offsets.
// ----------------------------------------------------------------------------
module sfp_apply_unit (
  input  sfp_pkg::sfp_grid_t cur,
  input  logic               x_mode,
  input  logic               y_mode,
  input  logic signed [4:0]  sx,
  input  logic signed [7:0]  sy,
  input  logic [7:0]         step_tenths,
  output sfp_pkg::sfp_grid_t nxt,
  output logic               changed
);

  logic [19:0]        decade;
  logic signed [20:0] decade_s;
  logic signed [25:0] t_prod;
  logic signed [26:0] time_s;
  logic signed [26:0] t_sum;
  logic [24:0]        t_clamp;
  logic [24:0]        t_wrap;

  logic signed [8:0]  step_s;
  logic signed [13:0] x_prod;
  logic signed [31:0] x_off_s;
  logic signed [33:0] x_sum;

  logic signed [4:0]  volts_s;
  logic signed [12:0] y_prod;
  logic signed [31:0] y_off_s;
  logic signed [33:0] y_sum;

  logic signed [8:0]  v_sum;
  logic [7:0]         v_n;
  logic [15:0]        v_recip;
  logic [4:0]         v_q;
  logic [7:0]         v_qx11;
  logic [7:0]         v_rem;
  logic [3:0]         volts_new;

  // time/div: step by the current decade, clamp low, wrap once
  assign decade   = sfp_pkg::decade_of(cur.time_div);
  assign decade_s = {1'b0, decade};
  assign t_prod   = decade_s * sx;
  assign time_s   = {3'b000, cur.time_div};
  assign t_sum    = time_s + 27'(t_prod);
  assign t_clamp  = (t_sum < 27'sd1) ? 25'd1 : t_sum[24:0];
  assign t_wrap   = (t_clamp >= sfp_pkg::TIME_WRAP) ? t_clamp - sfp_pkg::TIME_WRAP : t_clamp;

  // X offset
  assign step_s  = {1'b0, step_tenths};
  assign x_prod  = sx * step_s;
  assign x_off_s = cur.x_pos;
  assign x_sum   = 34'(x_off_s) + 34'(x_prod);

  // Y offset
  assign volts_s = {1'b0, cur.volts_div};
  assign y_prod  = sy * volts_s;
  assign y_off_s = cur.y_pos;
  assign y_sum   = 34'(y_off_s) + 34'(y_prod);

  // volts/div: positive sums reduce mod 11 by reciprocal; zero or below, or a zero remainder, gives 1
  assign v_sum   = 9'(sy) + 9'(volts_s);
  assign v_n     = v_sum[7:0];
  assign v_recip = {8'b0, v_n} * sfp_pkg::VOLTS_RECIP;
  assign v_q     = v_recip[15:11];
  assign v_qx11  = {v_q, 3'b000} + {2'b00, v_q, 1'b0} + {3'b000, v_q};
  assign v_rem   = v_n - v_qx11;
  assign volts_new = ((v_sum <= 9'sd0) || (v_rem == 8'd0)) ? 4'd1 : v_rem[3:0];

  always_comb begin
    nxt     = cur;
    changed = 1'b0;
    if (sx != 5'sd0) begin
      if (x_mode) begin
        nxt.x_pos = sfp_pkg::sat32(x_sum);
      end else begin
        nxt.time_div = t_wrap[23:0];
      end
      changed = 1'b1;
    end
    if (sy != 8'sd0) begin
      if (y_mode) begin
        nxt.y_pos = sfp_pkg::sat32(y_sum);
      end else begin
        nxt.volts_div = volts_new;
      end
      changed = 1'b1;
    end
  end

endmodule

@@ rtl/core/scope_front_panel_control_top.sv @@
// An accepted item passes through the input register, then the result
//   register; one item per cycle sustained while the output is not stalled.
// A stalled result holds the result register while the input register, if
//   empty, still takes one more item.
// Reset (rst, synchronous, active high) clears both stages and loads the
//   panel state: time/div 1000 us, volts/div 1, X step 3 tenths, rest zero.
// ----------------------------------------------------------------------------
// scope_front_panel_control_top
// Front-panel event processor for an oscilloscope: encoder steps, knob mode
// buttons, pause and wave select, and applying accumulated steps to the grid.
// ----------------------------------------------------------------------------
module scope_front_panel_control_top #(
  parameter int unsigned WAVE_KINDS = sfp_pkg::WAVE_KINDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  // Input item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  command,
  input  logic                        clock_level,
  input  logic                        data_level,
  input  logic                        x_button_level,
  input  logic                        y_button_level,

  // Result item channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [23:0]                 time_per_division,
  output logic [3:0]                  volts_per_division,
  output logic signed [31:0]          x_offset_tenths,
  output logic signed [31:0]          y_offset_volts,
  output logic                        x_shift_mode,
  output logic                        y_shift_mode,
  output logic                        paused,
  output logic [2:0]                  wave_select,
  output logic                        grid_changed,
  output logic                        x_mode_toggled,
  output logic                        y_mode_toggled,

  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic [2:0] WAVE_LAST = 3'(WAVE_KINDS - 1);

  // Configuration register
  logic [7:0] x_shift_step;

  // Input register stage
  logic       stage_valid;
  logic [2:0] stage_cmd;
  logic       stage_clock;
  logic       stage_data;
  logic       stage_xb;
  logic       stage_yb;

  // Panel state
  logic signed [4:0]  x_count, x_count_next;
  logic signed [7:0]  y_count, y_count_next;
  logic               x_mode, x_mode_next;
  logic               y_mode, y_mode_next;
  logic               x_last, x_last_next;
  logic               y_last, y_last_next;
  sfp_pkg::sfp_grid_t grid, grid_next;
  logic               pause, pause_next;
  logic [2:0]         wave, wave_next;

  logic grid_pulse, x_pulse, y_pulse;

  logic               advance;
  logic               dir_up;
  logic signed [5:0]  x_inc;
  logic signed [8:0]  y_inc;
  sfp_pkg::sfp_grid_t grid_applied;
  logic               apply_changed;

  // Move the staged item into the result register when it is free or drains
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || !out_valid || out_ready;

  // Configuration port: always ready, one register at index 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sfp_pkg::REG_X_SHIFT_STEP) ? {24'b0, x_shift_step} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_shift_step <= sfp_pkg::X_SHIFT_STEP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == sfp_pkg::REG_X_SHIFT_STEP)) begin
      x_shift_step <= pwdata[7:0];
    end
  end

  // Capture an item into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd   <= command;
      stage_clock <= clock_level;
      stage_data  <= data_level;
      stage_xb    <= x_button_level;
      stage_yb    <= y_button_level;
    end
  end

  // Grid arithmetic for the apply command
  sfp_apply_unit u_apply (
    .cur         (grid),
    .x_mode      (x_mode),
    .y_mode      (y_mode),
    .sx          (x_count),
    .sy          (y_count),
    .step_tenths (x_shift_step),
    .nxt         (grid_applied),
    .changed     (apply_changed)
  );

  // Encoder turns clockwise when data differs from clock
  assign dir_up = stage_clock ^ stage_data;
  assign x_inc  = 6'(x_count) + (dir_up ? 6'sd1 : -6'sd1);
  assign y_inc  = 9'(y_count) + (dir_up ? 9'sd1 : -9'sd1);

  always_comb begin
    x_count_next = x_count;
    y_count_next = y_count;
    x_mode_next  = x_mode;
    y_mode_next  = y_mode;
    x_last_next  = x_last;
    y_last_next  = y_last;
    grid_next    = grid;
    pause_next   = pause;
    wave_next    = wave;
    grid_pulse   = 1'b0;
    x_pulse      = 1'b0;
    y_pulse      = 1'b0;
    case (stage_cmd)
      sfp_pkg::CMD_X_EDGE: begin
        // Truncating remainder by 10: only plus or minus ten can wrap
        if ((x_inc == 6'sd10) || (x_inc == -6'sd10)) begin
          x_count_next = 5'sd0;
        end else begin
          x_count_next = x_inc[4:0];
        end
      end
      sfp_pkg::CMD_Y_EDGE: begin
        if (y_inc > 9'sd127) begin
          y_count_next = 8'sd127;
        end else if (y_inc < -9'sd128) begin
          y_count_next = -8'sd128;
        end else begin
          y_count_next = y_inc[7:0];
        end
      end
      sfp_pkg::CMD_CAPTURE: begin
        pause_next = !pause;
      end
      sfp_pkg::CMD_MODE: begin
        wave_next = (wave == WAVE_LAST) ? 3'd0 : wave + 3'd1;
      end
      sfp_pkg::CMD_BUTTONS: begin
        // Toggle a knob mode on the rising edge of its push switch
        if (stage_xb && !x_last) begin
          x_mode_next = !x_mode;
          x_pulse     = 1'b1;
        end
        if (stage_yb && !y_last) begin
          y_mode_next = !y_mode;
          y_pulse     = 1'b1;
        end
        x_last_next = stage_xb;
        y_last_next = stage_yb;
      end
      sfp_pkg::CMD_APPLY: begin
        grid_next    = grid_applied;
        grid_pulse   = apply_changed;
        x_count_next = 5'sd0;
        y_count_next = 8'sd0;
      end
      default: begin
        // Unused commands report status only
      end
    endcase
  end

  // Advance panel state on each item that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count        <= 5'sd0;
      y_count        <= 8'sd0;
      x_mode         <= 1'b0;
      y_mode         <= 1'b0;
      x_last         <= 1'b0;
      y_last         <= 1'b0;
      grid.time_div  <= sfp_pkg::TIME_RESET;
      grid.volts_div <= sfp_pkg::VOLTS_RESET;
      grid.x_pos     <= 32'sd0;
      grid.y_pos     <= 32'sd0;
      pause          <= 1'b0;
      wave           <= 3'd0;
    end else if (advance) begin
      x_count <= x_count_next;
      y_count <= y_count_next;
      x_mode  <= x_mode_next;
      y_mode  <= y_mode_next;
      x_last  <= x_last_next;
      y_last  <= y_last_next;
      grid    <= grid_next;
      pause   <= pause_next;
      wave    <= wave_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      time_per_division  <= grid_next.time_div;
      volts_per_division <= grid_next.volts_div;
      x_offset_tenths    <= grid_next.x_pos;
      y_offset_volts     <= grid_next.y_pos;
      x_shift_mode       <= x_mode_next;
      y_shift_mode       <= y_mode_next;
      paused             <= pause_next;
      wave_select        <= wave_next;
      grid_changed       <= grid_pulse;
      x_mode_toggled     <= x_pulse;
      y_mode_toggled     <= y_pulse;
    end
  end

`ifndef NO_ASSERTIONS
  // X count stays inside the wrap window
  a_x_count_range: assert property (@(posedge clk) disable iff (rst)
    (x_count <= 5'sd9) && (x_count >= -5'sd9))
    else $error("x step count outside -9..9");

  // volts/div never leaves 1..10
  a_volts_range: assert property (@(posedge clk) disable iff (rst)
    (grid.volts_div >= 4'd1) && (grid.volts_div <= 4'd10))
    else $error("volts/div outside 1..10");

  // time/div wraps below the wrap value
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    grid.time_div < 24'd10000001)
    else $error("time/div above limit");

  // An applied item drains both step counts
  a_apply_drains: assert property (@(posedge clk) disable iff (rst)
    (advance && (stage_cmd == sfp_pkg::CMD_APPLY)) |=> (x_count == 5'sd0) && (y_count == 8'sd0))
    else $error("apply left step counts nonzero");

  // Wave select stays below the number of kinds
  a_wave_range: assert property (@(posedge clk) disable iff (rst)
    wave <= WAVE_LAST)
    else $error("wave select out of range");
`endif

endmodule

@@ bench/panel_status_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_status_checker
// Watches the event, status and register channels of the front-panel block.
// It keeps its own copy of the panel state, works out the status for each
// accepted event and compares each returned status with the oldest one due.
// ----------------------------------------------------------------------------
module panel_status_checker #(
  parameter int unsigned WAVE_KINDS = sfp_pkg::WAVE_KINDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  command,
  input  logic                        clock_level,
  input  logic                        data_level,
  input  logic                        x_button_level,
  input  logic                        y_button_level,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [23:0]                 time_per_division,
  input  logic [3:0]                  volts_per_division,
  input  logic signed [31:0]          x_offset_tenths,
  input  logic signed [31:0]          y_offset_volts,
  input  logic                        x_shift_mode,
  input  logic                        y_shift_mode,
  input  logic                        paused,
  input  logic [2:0]                  wave_select,
  input  logic                        grid_changed,
  input  logic                        x_mode_toggled,
  input  logic                        y_mode_toggled,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);

  localparam int     X_COUNT_WRAP = 10;
  localparam int     Y_COUNT_MAX  = 127;
  localparam int     Y_COUNT_MIN  = -128;
  localparam longint TIME_MOD     = 10000001;
  localparam longint DECADE_TOP   = 1000000;
  localparam longint VOLTS_MOD    = 11;
  localparam longint S32_HI       = 64'sd2147483647;
  localparam longint S32_LO       = -64'sd2147483648;

  typedef struct packed {
    logic [23:0] time_div;
    logic [3:0]  volts_div;
    logic [31:0] x_off;
    logic [31:0] y_off;
    logic        x_shift;
    logic        y_shift;
    logic        paused;
    logic [2:0]  wave;
    logic        grid;
    logic        x_tog;
    logic        y_tog;
  } panel_status_t;

  // Panel state as the block should hold it
  longint      x_step_tenths;
  int          x_steps;
  int          y_steps;
  bit          x_shift_on;
  bit          y_shift_on;
  bit          x_btn_prev;
  bit          y_btn_prev;
  bit          pause_on;
  longint      time_div;
  longint      volts_div;
  longint      x_off;
  longint      y_off;
  int unsigned wave;

  panel_status_t pending_status[$];
  int            result_index;

  task automatic report_mismatch(input string what);
    begin
      $display("[%0t] result %0d: %s", $time, result_index, what);
      fail_count = fail_count + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    begin
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
    end
  endtask

  function automatic longint clamp_s32(input longint v);
    begin
      if (v > S32_HI) begin
        return S32_HI;
      end
      if (v < S32_LO) begin
        return S32_LO;
      end
      return v;
    end
  endfunction

  // Step size of the time scale: the power of ten at or below t
  function automatic longint time_decade(input longint t);
    longint f;
    begin
      f = DECADE_TOP;
      while (f > 1 && t < f) begin
        f = f / 10;
      end
      return f;
    end
  endfunction

  task automatic reset_panel();
    begin
      x_step_tenths = sfp_pkg::X_SHIFT_STEP_RESET;
      x_steps       = 0;
      y_steps       = 0;
      x_shift_on    = 1'b0;
      y_shift_on    = 1'b0;
      x_btn_prev    = 1'b0;
      y_btn_prev    = 1'b0;
      pause_on      = 1'b0;
      time_div      = sfp_pkg::TIME_RESET;
      volts_div     = sfp_pkg::VOLTS_RESET;
      x_off         = 0;
      y_off         = 0;
      wave          = 0;
    end
  endtask

  function automatic panel_status_t advance_panel(input logic [2:0] cmd,
                                                  input logic clk_lv,
                                                  input logic dat_lv,
                                                  input logic xb,
                                                  input logic yb);
    panel_status_t s;
    bit            up;
    longint        sx;
    longint        sy;
    longint        t;
    begin
      up      = (clk_lv != dat_lv);
      s.grid  = 1'b0;
      s.x_tog = 1'b0;
      s.y_tog = 1'b0;
      case (cmd)
        sfp_pkg::CMD_X_EDGE: begin
          x_steps = (x_steps + (up ? 1 : -1)) % X_COUNT_WRAP;
        end
        sfp_pkg::CMD_Y_EDGE: begin
          y_steps = y_steps + (up ? 1 : -1);
          if (y_steps > Y_COUNT_MAX) begin
            y_steps = Y_COUNT_MAX;
          end else if (y_steps < Y_COUNT_MIN) begin
            y_steps = Y_COUNT_MIN;
          end
        end
        sfp_pkg::CMD_CAPTURE: begin
          pause_on = !pause_on;
        end
        sfp_pkg::CMD_MODE: begin
          wave = (wave + 1) % WAVE_KINDS;
        end
        sfp_pkg::CMD_BUTTONS: begin
          if (xb && !x_btn_prev) begin
            x_shift_on = !x_shift_on;
            s.x_tog    = 1'b1;
          end
          x_btn_prev = xb;
          if (yb && !y_btn_prev) begin
            y_shift_on = !y_shift_on;
            s.y_tog    = 1'b1;
          end
          y_btn_prev = yb;
        end
        sfp_pkg::CMD_APPLY: begin
          sx      = x_steps;
          sy      = y_steps;
          x_steps = 0;
          y_steps = 0;
          if (sx != 0) begin
            if (x_shift_on) begin
              x_off = clamp_s32(x_off + sx * x_step_tenths);
            end else begin
              t = time_div + time_decade(time_div) * sx;
              if (t < 1) begin
                t = 1;
              end
              time_div = t % TIME_MOD;
            end
            s.grid = 1'b1;
          end
          if (sy != 0) begin
            if (y_shift_on) begin
              y_off = clamp_s32(y_off + sy * volts_div);
            end else begin
              t = (volts_div + sy) % VOLTS_MOD;
              if (t < 1) begin
                t = 1;
              end
              volts_div = t;
            end
            s.grid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      s.time_div  = time_div[23:0];
      s.volts_div = volts_div[3:0];
      s.x_off     = x_off[31:0];
      s.y_off     = y_off[31:0];
      s.x_shift   = x_shift_on;
      s.y_shift   = y_shift_on;
      s.paused    = pause_on;
      s.wave      = wave[2:0];
      return s;
    end
  endfunction

  always @(posedge clk) begin
    panel_status_t want;
    if (rst) begin
      reset_panel();
      pending_status.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == sfp_pkg::REG_X_SHIFT_STEP) begin
            x_step_tenths = pwdata[7:0];
          end
        end else if (paddr[2] == sfp_pkg::REG_X_SHIFT_STEP) begin
          check_field("x_shift_step_tenths readback", prdata, x_step_tenths[31:0]);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("status item with no event waiting");
        end else begin
          want = pending_status.pop_front();
          check_field("time_per_division", time_per_division, want.time_div);
          check_field("volts_per_division", volts_per_division, want.volts_div);
          check_field("x_offset_tenths", x_offset_tenths, want.x_off);
          check_field("y_offset_volts", y_offset_volts, want.y_off);
          check_field("x_shift_mode", x_shift_mode, want.x_shift);
          check_field("y_shift_mode", y_shift_mode, want.y_shift);
          check_field("paused", paused, want.paused);
          check_field("wave_select", wave_select, want.wave);
          check_field("grid_changed", grid_changed, want.grid);
          check_field("x_mode_toggled", x_mode_toggled, want.x_tog);
          check_field("y_mode_toggled", y_mode_toggled, want.y_tog);
        end
        result_index = result_index + 1;
      end
      if (in_valid && in_ready) begin
        pending_status.push_back(advance_panel(command, clock_level, data_level,
                                               x_button_level, y_button_level));
      end
    end
    pending = pending_status.size();
  end

endmodule

@@ bench/scope_front_panel_control_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_front_panel_control_top_tb
// Drives front-panel events and register accesses into the control block.
// A directed opening and two scripted knob walks hit the counter, scale and
// mode corners; random event sequences with idling and a long output stall
// follow. A separate checker predicts and compares every status item.
// ----------------------------------------------------------------------------
module scope_front_panel_control_top_tb;

  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 4;     // two pipeline stages plus margin
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned HOLD_CYCLES  = 60;

  // Commands the block must ignore apart from reporting status
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [sfp_pkg::PADDR_W-1:0] STEP_ADDR  = {sfp_pkg::REG_X_SHIFT_STEP, 2'b00};
  localparam logic [sfp_pkg::PADDR_W-1:0] SPARE_ADDR = {~sfp_pkg::REG_X_SHIFT_STEP, 2'b00};

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [2:0]                  command;
  logic                        clock_level;
  logic                        data_level;
  logic                        x_button_level;
  logic                        y_button_level;
  logic                        out_valid;
  logic                        out_ready;
  logic [23:0]                 time_per_division;
  logic [3:0]                  volts_per_division;
  logic signed [31:0]          x_offset_tenths;
  logic signed [31:0]          y_offset_volts;
  logic                        x_shift_mode;
  logic                        y_shift_mode;
  logic                        paused;
  logic [2:0]                  wave_select;
  logic                        grid_changed;
  logic                        x_mode_toggled;
  logic                        y_mode_toggled;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sfp_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  int fail_count;
  int pending;
  int sent         = 0;
  int idle_cycles  = 0;
  bit steady       = 1'b0;  // no idling on either side while set
  bit hold_request = 1'b0;  // flips to ask the receiver for one long stall

  scope_front_panel_control_top DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .clock_level        (clock_level),
    .data_level         (data_level),
    .x_button_level     (x_button_level),
    .y_button_level     (y_button_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .time_per_division  (time_per_division),
    .volts_per_division (volts_per_division),
    .x_offset_tenths    (x_offset_tenths),
    .y_offset_volts     (y_offset_volts),
    .x_shift_mode       (x_shift_mode),
    .y_shift_mode       (y_shift_mode),
    .paused             (paused),
    .wave_select        (wave_select),
    .grid_changed       (grid_changed),
    .x_mode_toggled     (x_mode_toggled),
    .y_mode_toggled     (y_mode_toggled),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  panel_status_checker CHECK (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .clock_level        (clock_level),
    .data_level         (data_level),
    .x_button_level     (x_button_level),
    .y_button_level     (y_button_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .time_per_division  (time_per_division),
    .volts_per_division (volts_per_division),
    .x_offset_tenths    (x_offset_tenths),
    .y_offset_volts     (y_offset_volts),
    .x_shift_mode       (x_shift_mode),
    .y_shift_mode       (y_shift_mode),
    .paused             (paused),
    .wave_select        (wave_select),
    .grid_changed       (grid_changed),
    .x_mode_toggled     (x_mode_toggled),
    .y_mode_toggled     (y_mode_toggled),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one item at the falling edge and hold it until the block takes it.
  // Valid stays high into the next item unless an idle gap is drawn, so it is
  // never dropped and raised in the same step.
  task automatic send_item(input logic [2:0] cmd, input logic clk_lv,
                           input logic dat_lv, input logic xb, input logic yb);
    int gap;
    begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 99) < 7) begin
        in_valid = 1'b0;
        gap = $urandom_range(1, 4);
        repeat (gap) @(negedge clk);
      end
      in_valid       = 1'b1;
      command        = cmd;
      clock_level    = clk_lv;
      data_level     = dat_lv;
      x_button_level = xb;
      y_button_level = yb;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent = sent + 1;
    end
  endtask

  // One encoder edge; the direction is up when data differs from clock.
  // Button levels ride along at random since edges must ignore them.
  task automatic knob_edge(input bit y_knob, input bit up);
    logic clk_lv;
    begin
      clk_lv = coin();
      send_item(y_knob ? sfp_pkg::CMD_Y_EDGE : sfp_pkg::CMD_X_EDGE,
                clk_lv, clk_lv ^ up, coin(), coin());
    end
  endtask

  // Load the X counter with n steps, then apply them
  task automatic x_apply_steps(input int n);
    begin
      repeat ((n < 0) ? -n : n) knob_edge(1'b0, n > 0);
      send_item(sfp_pkg::CMD_APPLY, coin(), coin(), coin(), coin());
    end
  endtask

  // A run of edges on one knob, mostly in one direction. The Y knob now and
  // then gets a run long enough to pin its counter at the limit.
  task automatic knob_burst(input bit y_knob);
    int len;
    bit up;
    begin
      if (y_knob && $urandom_range(0, 14) == 0) begin
        len = $urandom_range(128, 140);
      end else begin
        len = $urandom_range(1, y_knob ? 20 : 12);
      end
      up = coin();
      repeat (len) knob_edge(y_knob, ($urandom_range(0, 99) < 85) ? up : !up);
    end
  endtask

  // Register access: setup phase, then access phase until pready
  task automatic reg_access(input bit write, input logic [sfp_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] data);
    begin
      @(negedge clk);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = addr;
      pwdata  = data;
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
    end
  endtask

  // Drop valid, wait for every status item, then let the pipeline empty
  task automatic settle();
    begin
      @(negedge clk);
      in_valid = 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request,
  // counted here so the sender keeps offering items meanwhile.
  initial begin
    int hold_left;
    bit hold_seen;
    out_ready = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_request;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready = steady || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("scope_front_panel_control_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int         phase_end;
    int         pick;
    logic [7:0] step;

    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = sfp_pkg::CMD_X_EDGE;
    clock_level    = 1'b0;
    data_level     = 1'b0;
    x_button_level = 1'b0;
    y_button_level = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = STEP_ADDR;
    pwdata         = 32'd0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Read back the reset value of the step register
    reg_access(1'b0, STEP_ADDR, 32'd0);

    // Directed opening. Unused commands only report status.
    send_item(CMD_SPARE_LO, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(CMD_SPARE_HI, 1'b0, 1'b0, 1'b0, 1'b0);
    // Every clock/data pair on the X knob, leaving the X count at plus one
    send_item(sfp_pkg::CMD_X_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_X_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_X_EDGE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_X_EDGE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_X_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    // Two Y steps down: volts/div goes below one and clamps back to one
    send_item(sfp_pkg::CMD_Y_EDGE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_Y_EDGE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
    // Nothing left to drain: no grid change
    send_item(sfp_pkg::CMD_APPLY, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(sfp_pkg::CMD_CAPTURE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_CAPTURE, 1'b1, 1'b1, 1'b1, 1'b1);
    // Five mode presses take the wave selector all the way round
    repeat (5) send_item(sfp_pkg::CMD_MODE, 1'b0, 1'b0, 1'b0, 1'b0);
    // Press both knobs, hold, release X, press X again while releasing Y
    send_item(sfp_pkg::CMD_BUTTONS, 1'b0, 1'b0, 1'b1, 1'b1);
    send_item(sfp_pkg::CMD_BUTTONS, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(sfp_pkg::CMD_BUTTONS, 1'b0, 1'b0, 1'b0, 1'b1);
    send_item(sfp_pkg::CMD_BUTTONS, 1'b0, 1'b0, 1'b1, 1'b0);
    // X back in scale, Y in shift: one of each through apply
    send_item(sfp_pkg::CMD_Y_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_X_EDGE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(sfp_pkg::CMD_BUTTONS, 1'b1, 1'b0, 1'b0, 1'b0);

    // Time scale walk in X scale mode: clamp to 1, climb one decade at a time
    // to 9000001, land exactly on the wrap value, step up from zero, then clamp.
    x_apply_steps(-9);
    x_apply_steps(1);
    repeat (6) x_apply_steps(9);
    x_apply_steps(8);
    x_apply_steps(1);
    x_apply_steps(1);
    x_apply_steps(-1);
    // Ten steps one way bring the X counter back round to zero
    x_apply_steps(10);

    // Pin the Y counter at its upper limit and apply it as a shift
    repeat (135) knob_edge(1'b1, 1'b1);
    send_item(sfp_pkg::CMD_APPLY, 1'b0, 1'b0, 1'b0, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Reconfigure only while the block is idle
      settle();
      case (phase)
        0:       step = 8'hFF;
        1:       step = 8'h00;
        3:       step = 8'h01;
        default: step = 8'($urandom);
      endcase
      reg_access(1'b1, STEP_ADDR, {24'($urandom), step});
      reg_access(1'b1, SPARE_ADDR, $urandom);
      reg_access(1'b0, STEP_ADDR, 32'd0);

      // First phase runs with no idling anywhere; the second one starts with
      // a long output stall so the block fills up and backs up its input.
      steady = (phase == 0);
      if (phase == 1) begin
        hold_request = !hold_request;
      end

      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          knob_burst(1'(pick % 2));
          if ($urandom_range(0, 9) != 0) begin
            send_item(sfp_pkg::CMD_APPLY, coin(), coin(), coin(), coin());
          end
        end else if (pick < 65) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(sfp_pkg::CMD_BUTTONS, coin(), coin(), coin(), coin());
          end
        end else if (pick < 75) begin
          send_item(coin() ? sfp_pkg::CMD_CAPTURE : sfp_pkg::CMD_MODE,
                    coin(), coin(), coin(), coin());
        end else if (pick < 85) begin
          send_item(sfp_pkg::CMD_APPLY, coin(), coin(), coin(), coin());
        end else begin
          // Noise: any command code, unused ones included
          send_item(3'($urandom_range(0, 7)), coin(), coin(), coin(), coin());
        end
      end
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("scope_front_panel_control_top test passed");
    end else begin
      $display("scope_front_panel_control_top test failed");
    end
    $finish;
  end

endmodule
